FILE: hdl/dhc_pkg.sv
// dhc_pkg: shared types, constants and helpers for the depth histogram colorizer.
// Used by dhc_ram, dhc_div, dhc_seq and depth_histogram_colorizer; depends on nothing.
`timescale 1ns / 1ps

package dhc_pkg;

    localparam int DEPTH_PORT_BITS = 16;
    localparam int DEPTH_BITS      = 16;
    localparam int COUNT_BITS      = 20;
    localparam int QUOT_BITS       = 8;
    localparam int NUM_BITS        = COUNT_BITS + QUOT_BITS;
    localparam int STEP_BITS       = $clog2(QUOT_BITS);

    typedef logic [DEPTH_BITS-1:0] addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [NUM_BITS-1:0]   numer_t;
    typedef logic [QUOT_BITS-1:0]  quot_t;
    typedef logic [7:0]            color_t;

    localparam addr_t  TOP_BIN   = '1;
    localparam addr_t  ADDR_ZERO = '0;
    localparam addr_t  ADDR_ONE  = addr_t'(1);
    localparam count_t CMAX      = '1;
    localparam count_t COUNT_ONE = count_t'(1);

    localparam logic ACT_COUNT = 1'b0;
    localparam logic ACT_MAP   = 1'b1;

    localparam color_t ZERO_BLUE  = 8'd0;
    localparam color_t ZERO_GREEN = 8'd5;
    localparam color_t ZERO_RED   = 8'd20;
    localparam color_t MAP_GREEN  = 8'd0;

    typedef struct packed {
        logic   we;
        addr_t  waddr;
        count_t wdata;
        logic   re;
        addr_t  raddr;
    } ram_req_t;

    typedef struct packed {
        logic   start;
        numer_t numer;
        count_t total;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        logic  done;
        quot_t quot;
    } div_rsp_t;

    typedef struct packed {
        logic   valid;
        color_t blue;
        color_t green;
        color_t red;
        logic   frame_end;
    } res_t;

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
    endfunction

endpackage

FILE: hdl/dhc_ram.sv
// dhc_ram: histogram bin memory, one write and one read port, registered read data.
// Depends on dhc_pkg.
`timescale 1ns / 1ps

module dhc_ram (
    input  logic              clk,
    input  dhc_pkg::ram_req_t req,
    output dhc_pkg::count_t   rdata
);

    dhc_pkg::count_t mem [0:(1 << dhc_pkg::DEPTH_BITS)-1];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata <= mem[req.raddr];
        end
    end

endmodule

FILE: hdl/dhc_div.sv
// dhc_div: iterative restoring divider, one quotient bit per cycle, result clamped to 255.
// Depends on dhc_pkg.
`timescale 1ns / 1ps

module dhc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  dhc_pkg::div_req_t req,
    output dhc_pkg::div_rsp_t rsp
);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } dstate_t;

    localparam logic [dhc_pkg::STEP_BITS-1:0] STEP_LAST = dhc_pkg::STEP_BITS'(dhc_pkg::QUOT_BITS - 1);

    dstate_t                        state_reg, state_next;
    dhc_pkg::count_t                rem_reg, rem_next;
    dhc_pkg::count_t                total_reg, total_next;
    dhc_pkg::quot_t                 low_reg, low_next;
    dhc_pkg::quot_t                 quot_reg, quot_next;
    logic [dhc_pkg::STEP_BITS-1:0]  step_reg, step_next;
    logic                           done_reg, done_next;

    logic [dhc_pkg::COUNT_BITS:0]   trial;
    logic [dhc_pkg::COUNT_BITS:0]   diff;
    logic                           fits;
    dhc_pkg::count_t                hi;

    always_comb
    begin
        trial = {rem_reg, low_reg[dhc_pkg::QUOT_BITS-1]};
        diff  = trial - {1'b0, total_reg};
        fits  = trial >= {1'b0, total_reg};
        hi    = req.numer[dhc_pkg::NUM_BITS-1:dhc_pkg::QUOT_BITS];

        state_next = state_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        step_next  = step_reg;
        done_next  = 1'b0;

        case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    if (req.total == '0)
                    begin
                        quot_next = '0;
                        done_next = 1'b1;
                    end
                    else if (hi >= req.total)
                    begin
                        quot_next = '1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next   = hi;
                        total_next = req.total;
                        low_next   = req.numer[dhc_pkg::QUOT_BITS-1:0];
                        quot_next  = '0;
                        step_next  = '0;
                        state_next = D_RUN;
                    end
                end
            end
            D_RUN:
            begin
                rem_next  = fits ? diff[dhc_pkg::COUNT_BITS-1:0]
                                 : trial[dhc_pkg::COUNT_BITS-1:0];
                low_next  = {low_reg[dhc_pkg::QUOT_BITS-2:0], 1'b0};
                quot_next = {quot_reg[dhc_pkg::QUOT_BITS-2:0], fits};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        total_reg <= total_next;
        low_reg   <= low_next;
        quot_reg  <= quot_next;
    end

    assign rsp.busy = (state_reg == D_RUN);
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: hdl/dhc_seq.sv
// dhc_seq: sequencer for bin updates, running-sum sweep, clear sweep and map lookups.
// Depends on dhc_pkg; drives dhc_ram and dhc_div through request structs.
`timescale 1ns / 1ps

module dhc_seq (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic [dhc_pkg::DEPTH_PORT_BITS-1:0]  depth_value,
    input  logic                                 last_pixel,
    output dhc_pkg::ram_req_t                    ram_req,
    input  dhc_pkg::count_t                      ram_rdata,
    output dhc_pkg::div_req_t                    div_req,
    input  dhc_pkg::div_rsp_t                    div_rsp,
    output dhc_pkg::res_t                        res,
    input  logic                                 res_ready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CNT_RD,
        S_CNT_WR,
        S_SUM_START,
        S_SUM_FIRST,
        S_SUM_RUN,
        S_MAP_MUL,
        S_MAP_DIVGO,
        S_MAP_DIV,
        S_MAP_OUT
    } state_t;

    state_t           state_reg, state_next;
    dhc_pkg::addr_t   sweep_reg, sweep_next;
    dhc_pkg::addr_t   addr_reg, addr_next;
    logic             last_reg, last_next;
    logic             pend_reg, pend_next;
    logic             sums_ready_reg, sums_ready_next;
    dhc_pkg::count_t  top_reg, top_next;
    dhc_pkg::count_t  run_reg, run_next;
    dhc_pkg::numer_t  numer_reg, numer_next;
    dhc_pkg::color_t  blue_reg, blue_next;
    dhc_pkg::color_t  green_reg, green_next;
    dhc_pkg::color_t  red_reg, red_next;

    dhc_pkg::count_t  sum;

    always_comb
    begin
        sum = dhc_pkg::sat_add(ram_rdata, run_reg);

        state_next      = state_reg;
        sweep_next      = sweep_reg;
        addr_next       = addr_reg;
        last_next       = last_reg;
        pend_next       = pend_reg;
        sums_ready_next = sums_ready_reg;
        run_next        = run_reg;
        numer_next      = numer_reg;
        blue_next       = blue_reg;
        green_next      = green_reg;
        red_next        = red_reg;

        ram_req       = '0;
        div_req.start = 1'b0;
        div_req.numer = numer_reg;
        div_req.total = top_reg;
        res.valid     = 1'b0;
        res.blue      = blue_reg;
        res.green     = green_reg;
        res.red       = red_reg;
        res.frame_end = last_reg;
        in_stall      = (state_reg != S_IDLE);

        case (state_reg)
            S_CLEAR:
            begin
                ram_req.we      = 1'b1;
                ram_req.waddr   = sweep_reg;
                ram_req.wdata   = '0;
                sums_ready_next = 1'b0;
                sweep_next      = sweep_reg + dhc_pkg::ADDR_ONE;
                if (sweep_reg == dhc_pkg::TOP_BIN)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? S_CNT_RD : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next = depth_value[dhc_pkg::DEPTH_BITS-1:0];
                    last_next = last_pixel;
                    if (action == dhc_pkg::ACT_MAP)
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = depth_value[dhc_pkg::DEPTH_BITS-1:0];
                        state_next    = S_MAP_MUL;
                    end
                    else if (sums_ready_reg)
                    begin
                        pend_next  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        ram_req.re    = 1'b1;
                        ram_req.raddr = depth_value[dhc_pkg::DEPTH_BITS-1:0];
                        state_next    = S_CNT_WR;
                    end
                end
            end
            S_CNT_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = addr_reg;
                state_next    = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_reg;
                ram_req.wdata = dhc_pkg::sat_add(ram_rdata, dhc_pkg::COUNT_ONE);
                state_next    = last_reg ? S_SUM_START : S_IDLE;
            end
            S_SUM_START:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = dhc_pkg::ADDR_ONE;
                sweep_next    = dhc_pkg::ADDR_ONE;
                state_next    = S_SUM_FIRST;
            end
            S_SUM_FIRST:
            begin
                run_next      = ram_rdata;
                ram_req.re    = 1'b1;
                ram_req.raddr = sweep_reg + dhc_pkg::ADDR_ONE;
                sweep_next    = sweep_reg + dhc_pkg::ADDR_ONE;
                state_next    = S_SUM_RUN;
            end
            S_SUM_RUN:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = sweep_reg;
                ram_req.wdata = sum;
                run_next      = sum;
                if (sweep_reg == dhc_pkg::TOP_BIN)
                begin
                    sums_ready_next = 1'b1;
                    sweep_next      = dhc_pkg::ADDR_ZERO;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = sweep_reg + dhc_pkg::ADDR_ONE;
                    sweep_next    = sweep_reg + dhc_pkg::ADDR_ONE;
                end
            end
            S_MAP_MUL:
            begin
                if (addr_reg == dhc_pkg::ADDR_ZERO)
                begin
                    blue_next  = dhc_pkg::ZERO_BLUE;
                    green_next = dhc_pkg::ZERO_GREEN;
                    red_next   = dhc_pkg::ZERO_RED;
                    state_next = S_MAP_OUT;
                end
                else
                begin
                    // count * 255
                    numer_next = {ram_rdata, {dhc_pkg::QUOT_BITS{1'b0}}}
                               - {{dhc_pkg::QUOT_BITS{1'b0}}, ram_rdata};
                    state_next = S_MAP_DIVGO;
                end
            end
            S_MAP_DIVGO:
            begin
                div_req.start = 1'b1;
                state_next    = S_MAP_DIV;
            end
            S_MAP_DIV:
            begin
                if (div_rsp.done)
                begin
                    red_next   = div_rsp.quot;
                    blue_next  = ~div_rsp.quot;
                    green_next = dhc_pkg::MAP_GREEN;
                    state_next = S_MAP_OUT;
                end
            end
            S_MAP_OUT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = last_reg ? S_CLEAR : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // shadow copy of the top bin, used as the map divisor
        top_next = (ram_req.we && ram_req.waddr == dhc_pkg::TOP_BIN) ? ram_req.wdata : top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            sweep_reg      <= '0;
            pend_reg       <= 1'b0;
            sums_ready_reg <= 1'b0;
            top_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            pend_reg       <= pend_next;
            sums_ready_reg <= sums_ready_next;
            top_reg        <= top_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        last_reg  <= last_next;
        run_reg   <= run_next;
        numer_reg <= numer_next;
        blue_reg  <= blue_next;
        green_reg <= green_next;
        red_reg   <= red_next;
    end

endmodule

FILE: hdl/depth_histogram_colorizer.sv
// depth_histogram_colorizer: top level, bin memory, divider, sequencer and output register.
// Depends on dhc_pkg, dhc_ram, dhc_div and dhc_seq.
//
//   channel | handshake            | beat fields
//   --------+----------------------+-----------------------------------
//   in      | in_valid / in_stall  | action, depth_value, last_pixel
//   out     | out_valid / out_stall| blue, green, red, frame_end
//
// Count beat: bin read, then write-back; after the last count beat a running-sum
// sweep follows, one bin per cycle.
// Map beat: bin read, scaling, then the 8-step divider, which is skipped when the
// total is zero or the quotient clamps; zero depth skips scaling and divider.
// After reset and after the last map beat a clear sweep runs;
// a count beat after finished sums waits for the same sweep.
// The output register frees the sequencer while a result waits on out_stall.
`timescale 1ns / 1ps

module depth_histogram_colorizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic [dhc_pkg::DEPTH_PORT_BITS-1:0] depth_value,
    input  logic                                last_pixel,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          blue,
    output logic [7:0]                          green,
    output logic [7:0]                          red,
    output logic                                frame_end
);

    dhc_pkg::ram_req_t ram_req;
    dhc_pkg::count_t   ram_rdata;
    dhc_pkg::div_req_t div_req;
    dhc_pkg::div_rsp_t div_rsp;
    dhc_pkg::res_t     res;
    logic              res_ready;
    logic              load;

    logic              out_valid_reg, out_valid_next;
    dhc_pkg::color_t   blue_reg, green_reg, red_reg;
    logic              frame_end_reg;

    dhc_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    dhc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    dhc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .depth_value (depth_value),
        .last_pixel  (last_pixel),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata),
        .div_req     (div_req),
        .div_rsp     (div_rsp),
        .res         (res),
        .res_ready   (res_ready)
    );

    always_comb
    begin
        res_ready = !out_valid_reg || !out_stall;
        load      = res.valid && res_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            blue_reg      <= res.blue;
            green_reg     <= res.green;
            red_reg       <= res.red;
            frame_end_reg <= res.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign blue      = blue_reg;
    assign green     = green_reg;
    assign red       = red_reg;
    assign frame_end = frame_end_reg;

    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("sequencer took a beat but did not go busy");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("bin read and write hit the same entry");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_load_frees_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res_ready) |=> res.valid)
        else $error("result dropped while output register was held");

endmodule
